// File: rtl/gslg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel grid solver package
// Shared item codes, register indices, node types and the grid store size.
// ----------------------------------------------------------------------------
package gslg_pkg;

    // Side of the node store; the row and column fields address up to 64.
    localparam int GRID_MAX = 64;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_SOLVE = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    localparam logic [1:0] REG_GRID_SIZE  = 2'd0;
    localparam logic [1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [1:0] REG_MAX_SWEEPS = 2'd2;

    typedef logic signed [31:0] t_node;

endpackage

// File: rtl/gauss_seidel_laplace_grid_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel five-point Laplace grid solver
// Holds a square grid of Q16.16 nodes in one memory and relaxes it in place.
// ----------------------------------------------------------------------------
// Timing: a write gives no result; a read raises its result strobe after the
// states S_RD and S_RDOUT; a solve raises it at the end of its last sweep. On
// the single memory port each interior node steps through S_NODE, S_RE, S_RW,
// S_RN, S_RS, S_CALC and S_WR, with S_NEXT between nodes; a sweep ends in S_DONE.
// Throughput: one item at a time; busy is high from the transfer until the
// result strobe. The receiver cannot stall. Reset is synchronous, active low,
// restores the control and configuration registers; the node memory is not cleared.
module gauss_seidel_laplace_grid_solver
    import gslg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic signed [31:0] i_node_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic signed [31:0] o_node_out,
    output logic [15:0] o_sweep_count,
    output logic        o_converged
);
    localparam int AW = $clog2(GRID_MAX);
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam logic [7:0] GMAX8 = 8'(GRID_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDOUT, S_NODE, S_RE, S_RW, S_RN, S_RS, S_CALC, S_WR,
        S_NEXT, S_DONE
    } t_state;

    // The node memory: one synchronous port, reads registered.
    t_node r_mem [DEPTH];
    t_node r_q;
    logic [2*AW-1:0] n_addr;
    logic n_we;
    t_node n_wd;

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_addr] <= n_wd;
        r_q <= r_mem[n_addr];
    end

    t_state r_state;
    logic [6:0]  r_gsize;
    logic [30:0] r_tol;
    logic [15:0] r_maxs;
    logic [7:0]  r_n;
    logic [15:0] r_cap;
    logic [AW-1:0] r_i, r_j;
    logic [15:0] r_sweeps;
    logic [31:0] r_big;
    logic signed [33:0] r_sum;
    t_node r_old;
    logic [5:0] r_row, r_col;
    logic r_inside;

    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign busy = (r_state != S_IDLE);

    // Neighbor address selection per state.
    logic [2*AW-1:0] a_ctr;
    assign a_ctr = {r_i, r_j};
    always_comb begin
        n_we = 1'b0;
        n_wd = i_node_in;
        n_addr = a_ctr;
        unique case (r_state)
            S_IDLE: begin
                n_addr = {i_row[AW-1:0], i_col[AW-1:0]};
                n_we = start && (t_kind'(i_kind) == K_WRITE)
                       && ({2'b0, i_row} < GMAX8) && ({2'b0, i_col} < GMAX8);
            end
            // Keep the read address on the port so the data is still valid in S_RDOUT.
            S_RD:   n_addr = {r_row[AW-1:0], r_col[AW-1:0]};
            S_NODE: n_addr = a_ctr;
            S_RE:   n_addr = a_ctr + 1'b1;
            S_RW:   n_addr = a_ctr - 1'b1;
            S_RN:   n_addr = a_ctr + (2*AW)'(GRID_MAX);
            S_RS:   n_addr = a_ctr - (2*AW)'(GRID_MAX);
            S_WR: begin
                n_we = 1'b1;
                n_wd = t_node'(r_sum >>> 2);
            end
            default: n_addr = a_ctr;
        endcase
    end

    logic signed [32:0] w_d;
    logic [31:0] w_mag;
    assign w_d = 33'(signed'(r_sum >>> 2)) - 33'(r_old);
    assign w_mag = w_d[32] ? 32'(-w_d) : 32'(w_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gsize <= 7'd64;
            r_tol <= 31'd655;
            r_maxs <= 16'hFFFF;
            r_sweeps <= '0;
            r_big <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        unique case (i_cfg_index)
                            REG_GRID_SIZE:  r_gsize <= i_cfg_data[6:0];
                            REG_TOLERANCE:  r_tol <= i_cfg_data[30:0];
                            REG_MAX_SWEEPS: r_maxs <= i_cfg_data[15:0];
                            default: ;
                        endcase
                    end
                    r_row <= i_row;
                    r_col <= i_col;
                    r_inside <= ({2'b0, i_row} < GMAX8) && ({2'b0, i_col} < GMAX8);
                    if (start) begin
                        unique case (t_kind'(i_kind))
                            K_READ:  r_state <= S_RD;
                            K_SOLVE: begin
                                r_n <= (r_gsize < 7'd3) ? 8'd3 :
                                       ({1'b0, r_gsize} > GMAX8) ? GMAX8 : {1'b0, r_gsize};
                                r_cap <= (r_maxs == 16'd0) ? 16'd1 : r_maxs;
                                r_sweeps <= '0;
                                r_big <= '0;
                                r_i <= AW'(1);
                                r_j <= AW'(1);
                                r_state <= S_NODE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: r_state <= S_RDOUT;
                S_RDOUT: begin
                    o_strobe <= 1'b1;
                    o_node_out <= r_inside ? r_q : '0;
                    o_sweep_count <= '0;
                    o_converged <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_NODE: r_state <= S_RE;
                S_RE: begin
                    r_old <= r_q;
                    r_state <= S_RW;
                end
                S_RW: begin
                    r_sum <= 34'(r_q);
                    r_state <= S_RN;
                end
                S_RN: begin
                    r_sum <= r_sum + 34'(r_q);
                    r_state <= S_RS;
                end
                S_RS: begin
                    r_sum <= r_sum + 34'(r_q);
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_sum <= r_sum + 34'(r_q);
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (w_mag > r_big) r_big <= w_mag;
                    r_state <= S_NEXT;
                    if (8'(r_j) + 8'd2 < r_n) r_j <= r_j + 1'b1;
                    else begin
                        r_j <= AW'(1);
                        if (8'(r_i) + 8'd2 < r_n) r_i <= r_i + 1'b1;
                        else begin
                            r_i <= AW'(1);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_NEXT: r_state <= S_NODE;
                S_DONE: begin
                    r_sweeps <= r_sweeps + 16'd1;
                    r_big <= '0;
                    if ((r_big <= {1'b0, r_tol}) || (r_sweeps + 16'd1 >= r_cap)) begin
                        o_strobe <= 1'b1;
                        o_node_out <= '0;
                        o_sweep_count <= r_sweeps + 16'd1;
                        o_converged <= (r_big <= {1'b0, r_tol});
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_NODE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_busy_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("config accepted while busy");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$past(o_strobe)) else $error("double result");
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_node_out != 0) |-> (o_sweep_count == 16'd0))
        else $error("mixed result");
`endif
endmodule

// File: bench/gslg_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid solver result checker
// Follows item and register transfers, keeps its own copy of the grid and
// registers, and compares every result strobe with the oldest expected one.
// ----------------------------------------------------------------------------
module gslg_result_checker
    import gslg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [31:0] i_node_in,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_strobe,
    input  logic [31:0] i_node_out,
    input  logic [15:0] i_sweep_count,
    input  logic        i_converged,
    output int          o_pending,
    output int          o_errors
);

    typedef struct {
        logic [31:0] node;
        logic [15:0] sweeps;
        logic        conv;
    } t_result;

    localparam int SIDE = 64;

    logic [31:0] grid [SIDE][SIDE];
    logic [6:0]  grid_size;
    logic [30:0] tolerance;
    logic [15:0] max_sweeps;
    t_result     expected_results[$];

    assign o_pending = expected_results.size();

    // Relaxes the active grid in place and reports sweeps and convergence.
    function automatic void relax_grid(output logic [15:0] sweeps, output logic conv);
        int     n;
        int     cap;
        longint sum;
        longint nv;
        longint d;
        longint mag;
        longint big;
        bit     done;
        n = (grid_size < 3) ? 3 : ((grid_size > SIDE) ? SIDE : grid_size);
        cap = (max_sweeps == 0) ? 1 : max_sweeps;
        sweeps = '0;
        done = 0;
        big = 0;
        while (!done) begin
            big = 0;
            for (int i = 1; i < n - 1; i++) begin
                for (int j = 1; j < n - 1; j++) begin
                    sum = longint'($signed(grid[i][j+1])) + longint'($signed(grid[i][j-1]))
                        + longint'($signed(grid[i+1][j])) + longint'($signed(grid[i-1][j]));
                    nv = sum >>> 2;
                    d = nv - longint'($signed(grid[i][j]));
                    mag = (d < 0) ? -d : d;
                    grid[i][j] = nv[31:0];
                    if (mag > big) big = mag;
                end
            end
            sweeps = sweeps + 16'd1;
            if (big <= longint'(tolerance) || sweeps >= cap) done = 1;
        end
        conv = (big <= longint'(tolerance));
    endfunction

    always @(posedge i_clk) begin
        t_result r;
        t_result e;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            grid_size  <= 7'd64;
            tolerance  <= 31'd655;
            max_sweeps <= 16'd65535;
            expected_results.delete();
            o_errors   <= 0;
        end else begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("result strobe with no result expected");
                    errs++;
                end else begin
                    e = expected_results.pop_front();
                    if (i_node_out !== e.node) begin
                        $error("node_out: expected %h, got %h", e.node, i_node_out);
                        errs++;
                    end
                    if (i_sweep_count !== e.sweeps) begin
                        $error("sweep_count: expected %0d, got %0d", e.sweeps, i_sweep_count);
                        errs++;
                    end
                    if (i_converged !== e.conv) begin
                        $error("converged: expected %b, got %b", e.conv, i_converged);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_errors <= o_errors + errs;
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_GRID_SIZE:  grid_size  <= i_cfg_data[6:0];
                    REG_TOLERANCE:  tolerance  <= i_cfg_data[30:0];
                    REG_MAX_SWEEPS: max_sweeps <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                case (t_kind'(i_kind))
                    K_WRITE: grid[i_row][i_col] = i_node_in;
                    K_SOLVE: begin
                        r.node = '0;
                        relax_grid(r.sweeps, r.conv);
                        expected_results.push_back(r);
                    end
                    K_READ: begin
                        r.node = grid[i_row][i_col];
                        r.sweeps = '0;
                        r.conv = 1'b0;
                        expected_results.push_back(r);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: bench/tb_gauss_seidel_laplace_grid_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel grid solver testbench
// Fills the working corner of the node store, runs directed corner cases, then
// random phases of writes, reads, solves and no-op items under several
// register settings. A separate checker predicts every result; this module
// makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_gauss_seidel_laplace_grid_solver;
    import gslg_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [5:0]  i_row;
    logic [5:0]  i_col;
    logic signed [31:0] i_node_in;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_strobe;
    logic signed [31:0] o_node_out;
    logic [15:0] o_sweep_count;
    logic        o_converged;
    int          pending;
    int          errors;

    gauss_seidel_laplace_grid_solver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_row(i_row), .i_col(i_col), .i_node_in(i_node_in),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_node_out(o_node_out),
        .o_sweep_count(o_sweep_count), .o_converged(o_converged)
    );

    gslg_result_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_kind(i_kind), .i_row(i_row), .i_col(i_col), .i_node_in(i_node_in),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_strobe(o_strobe), .i_node_out(o_node_out),
        .i_sweep_count(o_sweep_count), .i_converged(o_converged),
        .o_pending(pending), .o_errors(errors)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs; far above the slowest correct run.
    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Random pause before an item: usually none, sometimes a short one,
    // now and then a long stretch so gaps land on every phase of a solve.
    task automatic idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return;
        start = 1'b0;
        if (pick < 95) repeat ($urandom_range(1, 3)) @(negedge i_clk);
        else repeat ($urandom_range(10, 60)) @(negedge i_clk);
    endtask

    // One item transfer. Start stays high into the next item when no gap
    // is inserted, so back-to-back transfers are exercised too.
    task automatic send_item(t_kind kind, logic [5:0] row, logic [5:0] col,
                             logic [31:0] value);
        idle_gap();
        start     = 1'b1;
        i_kind    = kind;
        i_row     = row;
        i_col     = col;
        i_node_in = value;
        @(posedge i_clk iff !busy);
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come back and the block has
    // been quiet for a while, since a write leaves no result behind it.
    task automatic drain();
        start = 1'b0;
        wait (pending == 0 && !busy);
        repeat (8) @(negedge i_clk);
    endtask

    // Register write transfer; bits above the register width carry noise.
    task automatic write_reg(logic [1:0] index, logic [31:0] value, int width);
        logic [31:0] noise;
        noise = $urandom();
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = (noise & ~((32'd1 << width) - 1)) | value;
        @(posedge i_clk iff o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(logic [6:0] size, logic [30:0] tol, logic [15:0] cap);
        drain();
        write_reg(REG_GRID_SIZE, size, 7);
        write_reg(REG_TOLERANCE, tol, 31);
        write_reg(REG_MAX_SWEEPS, cap, 16);
    endtask

    // Node values: mostly moderate so solves settle, some full-range.
    function automatic logic [31:0] node_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
        if (pick < 9) return $urandom();
        return (pick == 9 && $urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    // Random addresses stay inside the filled 16 x 16 corner.
    function automatic logic [5:0] near_addr();
        return 6'($urandom_range(0, 15));
    endfunction

    task automatic random_phase(int count, logic [6:0] size, logic [30:0] tol,
                                logic [15:0] cap);
        int pick;
        set_regs(size, tol, cap);
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(K_WRITE, near_addr(), near_addr(), node_value());
            else if (pick < 85)
                send_item(K_READ, near_addr(), near_addr(), $urandom());
            else if (pick < 95)
                send_item(K_SOLVE, near_addr(), near_addr(), $urandom());
            else
                send_item(K_NONE, near_addr(), near_addr(), $urandom());
        end
    endtask

    initial begin
        logic [6:0] size;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_kind      = K_WRITE;
        i_row       = '0;
        i_col       = '0;
        i_node_in   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_GRID_SIZE;
        i_cfg_data  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // The 16 x 16 corner is written first, so no later read or solve
        // touches an uninitialized location.
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                send_item(K_WRITE, 6'(r), 6'(c), node_value());

        // Directed part. The filled corner as one grid with a single sweep,
        // then the same with a zero cap.
        set_regs(7'd16, 31'd655, 16'd1);
        send_item(K_SOLVE, 0, 0, 0);
        set_regs(7'd16, 31'd655, 16'd0);
        send_item(K_SOLVE, 0, 0, 0);

        // Smallest grid, a tolerance of 1, largest cap: extreme values
        // around the single interior node.
        set_regs(7'd3, 31'd1, 16'd65535);
        send_item(K_WRITE, 0, 1, 32'h7FFF_FFFF);
        send_item(K_WRITE, 1, 0, 32'h7FFF_FFFF);
        send_item(K_WRITE, 1, 2, 32'h8000_0000);
        send_item(K_WRITE, 2, 1, 32'h8000_0000);
        send_item(K_WRITE, 1, 1, 32'h7FFF_FFFF);
        send_item(K_SOLVE, 0, 0, 0);
        send_item(K_READ, 1, 1, 0);
        send_item(K_WRITE, 0, 1, 32'hFFFF_FFFF);
        send_item(K_SOLVE, 0, 0, 0);
        send_item(K_READ, 1, 1, 0);
        send_item(K_WRITE, 63, 63, 32'h0123_4567);
        send_item(K_READ, 63, 63, 0);
        send_item(K_READ, 0, 0, 0);
        send_item(K_NONE, 63, 63, 32'hFFFF_FFFF);
        send_item(K_WRITE, 63, 0, 32'h8000_0000);
        send_item(K_READ, 63, 0, 0);

        // Undersized grid acts as the smallest; widest tolerance stops after one sweep.
        set_regs(7'd0, 31'h7FFF_FFFF, 16'd5);
        send_item(K_SOLVE, 0, 0, 0);
        send_item(K_READ, 1, 1, 0);
        set_regs(7'd2, 31'd1, 16'd3);
        send_item(K_SOLVE, 0, 0, 0);

        // Random phases. Small grids and low caps keep solves short; the
        // smallest grid is the only one paired with a large cap.
        for (int p = 0; p < 10; p++) begin
            size = 7'($urandom_range(3, 8));
            case (p)
                0: random_phase(155, 7'd3, 31'd1, 16'd65535);
                1: random_phase(155, 7'd1, 31'd655, 16'd0);
                2: random_phase(155, 7'd5, 31'h7FFF_FFFF, 16'd8);
                3: random_phase(155, 7'd4, 31'd1, 16'd6);
                default:
                    random_phase(155, size, 31'($urandom_range(1, 200_000)),
                                 16'($urandom_range(1, 8)));
            endcase
        end

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
